>>> sv/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types for the move-to-front recency list.
// ----------------------------------------------------------------------------
package mtf_pkg;

   // Control sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,   // link memory rebuild sweep
      ST_IDLE,    // waiting for a request beat
      ST_LINK,    // link words back: unlink the entry
      ST_HEAD,    // relink the entry at the front
      ST_DONE     // result waits for the output register
   } mtf_state_type;

endpackage

>>> sv/mtf_if.sv
// ----------------------------------------------------------------------------
// mtf_if
// Valid/ready channels of the move-to-front recency list.
// ----------------------------------------------------------------------------

// Request channel: one entry id per beat
interface mtf_req_if #(parameter int ID_W = 9);
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] request_id;

   modport source (output valid, output request_id, input ready);
   modport sink   (input valid, input request_id, output ready);
endinterface

// Response channel: current tail and error flag
interface mtf_rsp_if #(parameter int ID_W = 9);
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] lru_id;
   logic            bad_id;

   modport source (output valid, output lru_id, output bad_id, input ready);
   modport sink   (input valid, input lru_id, input bad_id, output ready);
endinterface

// Register write channel: entry count
interface mtf_csr_if #(parameter int ID_W = 9);
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] entries_in_use;

   modport source (output valid, output entries_in_use, input ready);
   modport sink   (input valid, input entries_in_use, output ready);
endinterface

>>> sv/move_to_front_lru_list.sv
// ----------------------------------------------------------------------------
// move_to_front_lru_list
// Recency order of entries 1..n kept as a doubly linked list in two link
// memories; each request moves its entry to the front and reports the tail.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                      | handshake
//  ---------+-----+------------------------------+------------
//  req_if   | in  | request_id                   | valid/ready
//  rsp_if   | out | lru_id, bad_id               | valid/ready
//  csr_if   | in  | entries_in_use               | valid/ready
//
//  Bad id or request for the head: nothing moves. Move: read links, unlink,
//  relink (ST_IDLE, ST_LINK, ST_HEAD), set by the single write port of each
//  link memory. After reset and after every count write the link memories
//  are rebuilt, one slot per cycle over slots 0..n-1 (MAX_ENTRIES slots
//  after reset); req_if.ready is low meanwhile. A stalled rsp_if holds one
//  result; the next request is still taken, waiting in ST_DONE until free.
// ----------------------------------------------------------------------------
module move_to_front_lru_list #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic      clock,
   input  logic      reset,
   mtf_req_if.sink   req_if,
   mtf_rsp_if.source rsp_if,
   mtf_csr_if.sink   csr_if
);

   import mtf_pkg::*;

   localparam int SLOT_W = $clog2(MAX_ENTRIES);
   localparam int ID_W   = $clog2(MAX_ENTRIES + 1);

   mtf_state_type state_ff, state_in;

   logic [ID_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              bad_ff, bad_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_lru_ff, rsp_lru_in;
   logic              rsp_bad_ff, rsp_bad_in;

   // Link memory ports
   logic              nx_we, px_we;
   logic [SLOT_W-1:0] nx_waddr, nx_wdata, px_waddr, px_wdata;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] nx_rdata, px_rdata;

   // Decoded inputs
   logic [ID_W-1:0]   req_dec;
   logic [SLOT_W-1:0] req_slot;
   logic              id_bad;
   logic [ID_W-1:0]   csr_sat;
   logic [ID_W-1:0]   csr_dec;
   logic [ID_W-1:0]   count_dec;
   logic [SLOT_W-1:0] last_slot;
   logic [ID_W-1:0]   tail_id;
   logic              out_free;
   logic              req_ready;

   // next_link memory: slot after each slot
   mtf_link_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(SLOT_W)) u_next_ram (
      .clock      (clock),
      .wr_en      (nx_we),
      .wr_addr    (nx_waddr),
      .wr_data    (nx_wdata),
      .rd_addr    (rd_addr),
      .rd_data_ff (nx_rdata)
   );

   // prev_link memory: slot before each slot
   mtf_link_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(SLOT_W)) u_prev_ram (
      .clock      (clock),
      .wr_en      (px_we),
      .wr_addr    (px_waddr),
      .wr_data    (px_wdata),
      .rd_addr    (rd_addr),
      .rd_data_ff (px_rdata)
   );

   // Request decode
   assign req_dec  = req_if.request_id - ID_W'(1);
   assign req_slot = req_dec[SLOT_W-1:0];
   assign id_bad   = (req_if.request_id == '0) || (req_if.request_id > count_ff);

   // Count write saturates to 1..MAX_ENTRIES
   always_comb begin
      if (csr_if.entries_in_use == '0) begin
         csr_sat = ID_W'(1);
      end else if (csr_if.entries_in_use > ID_W'(MAX_ENTRIES)) begin
         csr_sat = ID_W'(MAX_ENTRIES);
      end else begin
         csr_sat = csr_if.entries_in_use;
      end
   end

   assign csr_dec   = csr_sat - ID_W'(1);
   assign count_dec = count_ff - ID_W'(1);
   assign last_slot = count_dec[SLOT_W-1:0];
   assign tail_id   = ID_W'(tail_ff) + ID_W'(1);
   assign out_free  = !rsp_valid_ff || rsp_if.ready;

   // Sequencer: next state, memory ports and result loading
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      clr_in       = clr_ff;
      slot_in      = slot_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_lru_in   = rsp_lru_ff;
      rsp_bad_in   = rsp_bad_ff;
      nx_we        = 1'b0;
      nx_waddr     = clr_ff;
      nx_wdata     = clr_ff + SLOT_W'(1);
      px_we        = 1'b0;
      px_waddr     = clr_ff;
      px_wdata     = clr_ff - SLOT_W'(1);
      rd_addr      = req_slot;
      req_ready    = 1'b0;

      case (state_ff)
         // Rebuild: slot i links to i+1 and back to i-1
         ST_CLEAR: begin
            nx_we = 1'b1;
            px_we = 1'b1;
            if (clr_ff == last_slot) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + SLOT_W'(1);
            end
         end
         // Take a request; link words are read at its slot
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               slot_in = req_slot;
               bad_in  = id_bad;
               if (id_bad || (req_slot == head_ff)) begin
                  // nothing moves
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_lru_in   = tail_id;
                     rsp_bad_in   = id_bad;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  state_in = ST_LINK;
               end
            end
         end
         // Unlink: next[before] = after, prev[after] = before unless tail
         ST_LINK: begin
            nx_we    = 1'b1;
            nx_waddr = px_rdata;
            nx_wdata = nx_rdata;
            px_we    = (slot_ff != tail_ff);
            px_waddr = nx_rdata;
            px_wdata = px_rdata;
            if (slot_ff == tail_ff) begin
               tail_in = px_rdata;
            end
            state_in = ST_HEAD;
         end
         // Relink at the front: next[slot] = head, prev[head] = slot
         ST_HEAD: begin
            nx_we    = 1'b1;
            nx_waddr = slot_ff;
            nx_wdata = head_ff;
            px_we    = 1'b1;
            px_waddr = head_ff;
            px_wdata = slot_ff;
            head_in  = slot_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lru_in   = tail_id;
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         // Result waits for the output register
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lru_in   = tail_id;
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Count write restarts the order
      if (csr_if.valid) begin
         count_in = csr_sat;
         head_in  = '0;
         tail_in  = csr_dec[SLOT_W-1:0];
         clr_in   = '0;
         state_in = ST_CLEAR;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= ID_W'(MAX_ENTRIES);
         head_ff      <= '0;
         tail_ff      <= SLOT_W'(MAX_ENTRIES - 1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      bad_ff     <= bad_in;
      rsp_lru_ff <= rsp_lru_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   // Ports
   assign req_if.ready  = req_ready;
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.lru_id = rsp_lru_ff;
   assign rsp_if.bad_id = rsp_bad_ff;

   // Head and tail stay inside the tracked range
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (ID_W'(head_ff) < count_ff) && (ID_W'(tail_ff) < count_ff))
      else $error("head or tail beyond entry count");

   // A reported tail is always a tracked id
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_lru_ff != '0) && (rsp_lru_ff <= count_ff))
      else $error("lru_id outside 1..count");

   // A moved entry never links back to itself; the tail's next word is unused
   a_no_self_link: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINK) |-> (px_rdata != slot_ff) &&
         ((slot_ff == tail_ff) || (nx_rdata != slot_ff)))
      else $error("entry links to itself");

   // After a relink the moved entry is the head
   a_head_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HEAD) && !csr_if.valid |=> head_ff == $past(slot_ff))
      else $error("head not updated after move");

endmodule

>>> sv/mtf_link_ram.sv
// ----------------------------------------------------------------------------
// mtf_link_ram
// Single write port, single read port link memory with registered read data.
// ----------------------------------------------------------------------------
module mtf_link_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

>>> tb/tb_move_to_front_lru_list.sv
// ----------------------------------------------------------------------------
// tb_move_to_front_lru_list
// Self-checking bench for the move-to-front recency list. Named tests drive
// entry-id beats through the request channel and rewrite the entry count
// between phases. A local copy of the linked recency order predicts the tail
// id and the error flag of every response beat, which is checked in order.
// Both channels idle at random, with one long stretch of no idling, a long
// response hold-off that backs the block up, and full drains between phases.
// ----------------------------------------------------------------------------
module tb_move_to_front_lru_list;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ID_W        = 9;
   localparam int SLOTS       = 256;
   localparam int STALL_LIMIT = 3000;   // cycles with no beat on any channel
   localparam int HOLD_CYCLES = 300;    // long response hold-off
   localparam int SETTLE      = 8;      // quiet cycles before a count write

   typedef struct packed {
      logic [ID_W-1:0] lru_id;
      logic            bad_id;
   } tail_report_type;

   logic clock;
   logic reset;

   mtf_req_if #(.ID_W(ID_W)) req_if ();
   mtf_rsp_if #(.ID_W(ID_W)) rsp_if ();
   mtf_csr_if #(.ID_W(ID_W)) csr_if ();

   move_to_front_lru_list #(.MAX_ENTRIES(SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Recency order copy: zero-based slots, slot = id - 1
   logic [7:0]   next_slot [SLOTS];
   logic [7:0]   prev_slot [SLOTS];
   logic [7:0]   head_slot;
   logic [7:0]   tail_slot;
   int unsigned  entry_count;

   tail_report_type tail_expect_q [$];

   int  error_count   = 0;
   int  requests_sent = 0;
   int  bad_requests  = 0;
   int  results_seen  = 0;
   int  count_writes  = 0;
   bit  no_idle       = 1'b0;
   int  rsp_hold_left = 0;

   // Clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rebuild the order 1..n after reset or a count write
   function automatic void rebuild_order();
      for (int i = 0; i < SLOTS; i++) begin
         next_slot[i] = '0;
         prev_slot[i] = '0;
         if (i + 1 < entry_count) next_slot[i] = 8'(i + 1);
         if (i > 0 && i < entry_count) prev_slot[i] = 8'(i - 1);
      end
      head_slot = '0;
      tail_slot = 8'(entry_count - 1);
   endfunction

   // Saturate a raw count to 1..SLOTS and rebuild
   function automatic void load_entry_count(logic [ID_W-1:0] raw);
      if (raw == '0)
         entry_count = 1;
      else if (raw > SLOTS)
         entry_count = SLOTS;
      else
         entry_count = raw;
      rebuild_order();
   endfunction

   // Move the requested entry to the front; report the tail after it
   function automatic tail_report_type move_to_front(logic [ID_W-1:0] id);
      tail_report_type rep;
      logic [7:0]   slot;
      logic [7:0]   pred;
      logic [7:0]   succ;
      rep.bad_id = (id == '0) || (id > entry_count);
      if (!rep.bad_id) begin
         slot = 8'(id - 1);
         if (slot != head_slot) begin
            pred = prev_slot[slot];
            succ = next_slot[slot];
            next_slot[pred] = succ;
            if (slot == tail_slot)
               tail_slot = pred;
            else
               prev_slot[succ] = pred;
            next_slot[slot] = head_slot;
            prev_slot[slot] = '0;
            prev_slot[head_slot] = slot;
            head_slot = slot;
         end
      end
      rep.lru_id = ID_W'(tail_slot) + 1'b1;
      return rep;
   endfunction

   function automatic bit take_gap();
      return !no_idle && ($urandom_range(99) < 22);
   endfunction

   // Mostly valid ids, a share of head/tail hits, and some out-of-range noise
   function automatic logic [ID_W-1:0] pick_request_id();
      int r;
      r = $urandom_range(99);
      if (r < 80)
         return ID_W'($urandom_range(entry_count, 1));
      else if (r < 85)
         return ID_W'(tail_slot) + 1'b1;
      else if (r < 90)
         return ID_W'(head_slot) + 1'b1;
      else if (r < 93)
         return '0;
      else if (r < 97 && entry_count < 511)
         return ID_W'($urandom_range(511, entry_count + 1));
      else
         return ID_W'($urandom());
   endfunction

   // One request beat; called and returns at a rising edge
   task automatic send_request(input logic [ID_W-1:0] id);
      while (take_gap()) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.request_id <= id;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      tail_expect_q.push_back(move_to_front(id));
      requests_sent++;
      if ((id == '0) || (id > entry_count)) bad_requests++;
   endtask

   // Stop sending and wait until every response beat is in
   task automatic drain();
      req_if.valid <= 1'b0;
      while (tail_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Count write once the block is idle
   task automatic write_entry_count(input logic [ID_W-1:0] raw);
      drain();
      csr_if.valid          <= 1'b1;
      csr_if.entries_in_use <= raw;
      do @(negedge clock); while (!csr_if.ready);
      @(posedge clock);
      csr_if.valid <= 1'b0;
      load_entry_count(raw);
      count_writes++;
   endtask

   // ---------------------------------------------------------------- tests

   // Full-size order after reset: tail, head, middle and bad ids
   task automatic test_reset_order();
      send_request(9'd256);
      send_request(9'd1);
      send_request(9'd0);
      send_request(9'd257);
      send_request(9'd511);
      send_request(9'd255);
      send_request(9'd128);
      send_request(9'd128);
   endtask

   // One entry: always head and tail; count of zero saturates to one
   task automatic test_single_entry();
      write_entry_count(9'd0);
      send_request(9'd1);
      send_request(9'd2);
      send_request(9'd0);
      write_entry_count(9'd1);
      send_request(9'd1);
   endtask

   // Two entries swap on every tail request
   task automatic test_two_entries();
      write_entry_count(9'd2);
      send_request(9'd2);
      send_request(9'd2);
      send_request(9'd1);
      send_request(9'd3);
   endtask

   // Oversized count saturates to the full list
   task automatic test_count_saturation();
      write_entry_count(9'd511);
      send_request(9'd256);
      send_request(9'd300);
      send_request(9'd170);
   endtask

   // Random phases over a spread of counts
   task automatic test_random_phases();
      logic [ID_W-1:0] counts [8];
      counts = '{9'd3, 9'd8, 9'd256, 9'd5, 9'd17, 9'd1, 9'd0, 9'd64};
      for (int p = 0; p < 10; p++) begin
         if (p < 8)
            write_entry_count(counts[p]);
         else
            write_entry_count(ID_W'($urandom()));
         repeat (60) send_request(pick_request_id());
      end
   endtask

   // Response held off for a long stretch while requests keep coming
   task automatic test_backpressure();
      write_entry_count(9'd12);
      rsp_hold_left = HOLD_CYCLES;
      repeat (20) send_request(pick_request_id());
      drain();
   endtask

   // Long stretch with no idling on either side
   task automatic test_no_idle_stretch();
      write_entry_count(9'd6);
      no_idle = 1'b1;
      repeat (110) send_request(pick_request_id());
      no_idle = 1'b0;
   endtask

   // --------------------------------------------------------------- checking

   // Response ready: random idling, long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_if.ready <= no_idle || ($urandom_range(99) >= 22);
         end
      end
   end

   // Compare each response beat with the oldest prediction
   always @(negedge clock) begin
      tail_report_type want;
      if (rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (tail_expect_q.size() == 0) begin
            $display("%0t: unexpected beat lru_id=%0d bad_id=%0b",
                     $time, rsp_if.lru_id, rsp_if.bad_id);
            error_count++;
         end else begin
            want = tail_expect_q.pop_front();
            if (rsp_if.lru_id !== want.lru_id) begin
               $display("%0t: lru_id expected %0d actual %0d",
                        $time, want.lru_id, rsp_if.lru_id);
               error_count++;
            end
            if (rsp_if.bad_id !== want.bad_id) begin
               $display("%0t: bad_id expected %0b actual %0b",
                        $time, want.bad_id, rsp_if.bad_id);
               error_count++;
            end
         end
      end
   end

   // Watchdog: cycles with no beat on any channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no beat for %0d cycles, %0d responses outstanding",
               $time, STALL_LIMIT, tail_expect_q.size());
      $display("tb_move_to_front_lru_list failed");
      $finish;
   end

   // ------------------------------------------------------------------- main
   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.request_id     = '0;
      rsp_if.ready          = 1'b0;
      csr_if.valid          = 1'b0;
      csr_if.entries_in_use = '0;
      entry_count           = SLOTS;
      rebuild_order();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_order();
      test_single_entry();
      test_two_entries();
      test_count_saturation();
      test_random_phases();
      test_backpressure();
      test_no_idle_stretch();

      drain();
      repeat (20) @(posedge clock);
      if (tail_expect_q.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, tail_expect_q.size());
         error_count++;
      end
      $display("Covered %0d requests (%0d out of range), %0d responses, %0d count writes",
               requests_sent, bad_requests, results_seen, count_writes);
      $display("Counts from 1 to 256 incl. saturation, head/tail moves, long hold-off");
      if (error_count == 0)
         $display("tb_move_to_front_lru_list passed");
      else
         $display("tb_move_to_front_lru_list failed");
      $finish;
   end

endmodule

>>> move_to_front_lru_list.f
sv/mtf_pkg.sv
sv/mtf_if.sv
sv/mtf_link_ram.sv
sv/move_to_front_lru_list.sv
tb/tb_move_to_front_lru_list.sv
